### rtl/tcgr_pkg.sv
// ============================================================================
// tcgr_pkg
// Shared types, constants and colour functions of the text cell glyph renderer.
// ============================================================================
`default_nettype none

package tcgr_pkg;

    localparam int GLYPH_MAX_WIDTH  = 16;
    localparam int GLYPH_MAX_HEIGHT = 32;
    localparam int CHAR_COUNT       = 256;

    localparam int CHAR_W  = $clog2(CHAR_COUNT);
    localparam int ROW_W   = $clog2(GLYPH_MAX_HEIGHT);
    localparam int ADDR_W  = CHAR_W + ROW_W;
    localparam int DEPTH   = CHAR_COUNT * GLYPH_MAX_HEIGHT;
    localparam int FONT_W  = 16;
    localparam int COL_W   = 4;
    localparam int RGB_W   = 24;
    localparam int PACK_W  = 16;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register widths and reset values.
    localparam logic [2:0]  PIXEL_BYTES_RST  = 3'd4;
    localparam logic [4:0]  GLYPH_WIDTH_RST  = 5'd8;
    localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;
    localparam logic [14:0] CHAN_POS_RST     = 15'd11013;
    localparam logic [11:0] CHAN_SIZE_RST    = 12'd1381;
    localparam logic [2:0]  PIXEL_BYTES_PACKED = 3'd2;

    typedef enum logic [2:0] {
        REG_PIXEL_BYTES  = 3'd0,
        REG_GLYPH_WIDTH  = 3'd1,
        REG_GLYPH_HEIGHT = 3'd2,
        REG_CHAN_POS     = 3'd3,
        REG_CHAN_SIZE    = 3'd4
    } t_reg_idx;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_RENDER = 1'b1
    } t_cmd;

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] char_code;
        logic [4:0]        glyph_row;
        logic [7:0]        attribute;
        logic [FONT_W-1:0] font_bits;
    } t_in_item;

    typedef struct packed {
        logic [RGB_W-1:0] pixel_value;
        logic [COL_W-1:0] pixel_column;
        logic             last_pixel;
    } t_out_item;

    function automatic logic [RGB_W-1:0] palette(input logic [3:0] idx);
        logic [RGB_W-1:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0000aa;
            4'd2:    rgb = 24'h00aa00;
            4'd3:    rgb = 24'h00aaaa;
            4'd4:    rgb = 24'haa0000;
            4'd5:    rgb = 24'haa00aa;
            4'd6:    rgb = 24'haa5500;
            4'd7:    rgb = 24'haaaaaa;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'h5555ff;
            4'd10:   rgb = 24'h55ff55;
            4'd11:   rgb = 24'h55ffff;
            4'd12:   rgb = 24'hff5555;
            4'd13:   rgb = 24'hff55ff;
            4'd14:   rgb = 24'hffff55;
            default: rgb = 24'hffffff;
        endcase
        return rgb;
    endfunction

    // Truncates one 8-bit channel to its size and moves it to its position.
    // A size of zero shifts the whole channel out.
    function automatic logic [PACK_W-1:0] pack_channel(input logic [7:0] c8,
                                                       input logic [3:0] size,
                                                       input logic [4:0] pos);
        logic [3:0]  s;
        logic [7:0]  v;
        logic [39:0] wide;
        s    = (size > 4'd8) ? 4'd8 : size;
        v    = c8 >> (4'd8 - s);
        wide = {32'd0, v} << pos;
        return wide[PACK_W-1:0];
    endfunction

    function automatic logic [RGB_W-1:0] colour(input logic [3:0]  idx,
                                                input logic [2:0]  pixel_bytes,
                                                input logic [14:0] pos,
                                                input logic [11:0] sizes);
        logic [RGB_W-1:0]  rgb;
        logic [PACK_W-1:0] packed_px;
        rgb = palette(idx);
        packed_px = pack_channel(rgb[23:16], sizes[11:8], pos[14:10])
                  | pack_channel(rgb[15:8],  sizes[7:4],  pos[9:5])
                  | pack_channel(rgb[7:0],   sizes[3:0],  pos[4:0]);
        if (pixel_bytes != PIXEL_BYTES_PACKED) begin
            return rgb;
        end
        return {{(RGB_W-PACK_W){1'b0}}, packed_px};
    endfunction

endpackage

`default_nettype wire

### rtl/text_cell_glyph_renderer.sv
// ============================================================================
// text_cell_glyph_renderer
// Font store and pixel generator for one glyph row at a time.
// ============================================================================
// Items enter on i_item when start is high and busy is low. A write item
// stores one 16-bit font row at {char_code, glyph_row} and gives no result.
// A render item reads that row and gives one pixel per glyph column,
// leftmost first, on o_result with o_strobe high for one cycle each; the
// last one has last_pixel set. The receiver cannot stall the block.
// The font memory is read into a register in the accept cycle; the colours
// are formed and loaded into the pixel emitter with the font row once the
// emitter is free. Throughput: the emitter shifts out one column per cycle,
// for glyph_width columns capped at 16; the next render is taken while the
// current row is still going out. Writes are accepted whenever busy is low.
// Renders of rows at or above glyph_height, or with width zero, give nothing.
// Reset clears the control state and loads the register defaults. The font
// memory is not cleared and must be written before it is rendered. The user
// must write configuration over the APB port only while the block is idle;
// the block itself does not enforce this.
// ============================================================================
`default_nettype none

module text_cell_glyph_renderer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire tcgr_pkg::t_in_item             i_item,
    output logic                                o_strobe,
    output tcgr_pkg::t_out_item                 o_result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tcgr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tcgr_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcgr_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    // Configuration registers.
    logic [2:0]  r_pixel_bytes;
    logic [4:0]  r_glyph_width;
    logic [5:0]  r_glyph_height;
    logic [14:0] r_chan_pos;
    logic [11:0] r_chan_size;

    // Font memory and its registered read port.
    logic [tcgr_pkg::FONT_W-1:0] r_font_mem [tcgr_pkg::DEPTH];
    logic [tcgr_pkg::FONT_W-1:0] r_rd_data;

    // Lookup stage: a render whose font row is being read.
    logic       r_a_valid;
    logic [7:0] r_a_attr;

    // Pixel emitter.
    logic                        r_active;
    logic [tcgr_pkg::FONT_W-1:0] r_pat;
    logic [tcgr_pkg::RGB_W-1:0]  r_fg;
    logic [tcgr_pkg::RGB_W-1:0]  r_bg;
    logic [tcgr_pkg::COL_W-1:0]  r_col;
    logic [tcgr_pkg::COL_W-1:0]  r_last_col;

    logic                        accept;
    logic                        render_ok;
    logic                        e_free;
    logic [4:0]                  width;
    logic [tcgr_pkg::ADDR_W-1:0] addr;
    logic                        cfg_wr;
    tcgr_pkg::t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = tcgr_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes  <= tcgr_pkg::PIXEL_BYTES_RST;
            r_glyph_width  <= tcgr_pkg::GLYPH_WIDTH_RST;
            r_glyph_height <= tcgr_pkg::GLYPH_HEIGHT_RST;
            r_chan_pos     <= tcgr_pkg::CHAN_POS_RST;
            r_chan_size    <= tcgr_pkg::CHAN_SIZE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                tcgr_pkg::REG_PIXEL_BYTES:  r_pixel_bytes  <= pwdata[2:0];
                tcgr_pkg::REG_GLYPH_WIDTH:  r_glyph_width  <= pwdata[4:0];
                tcgr_pkg::REG_GLYPH_HEIGHT: r_glyph_height <= pwdata[5:0];
                tcgr_pkg::REG_CHAN_POS:     r_chan_pos     <= pwdata[14:0];
                tcgr_pkg::REG_CHAN_SIZE:    r_chan_size    <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tcgr_pkg::REG_PIXEL_BYTES:  prdata = {29'd0, r_pixel_bytes};
            tcgr_pkg::REG_GLYPH_WIDTH:  prdata = {27'd0, r_glyph_width};
            tcgr_pkg::REG_GLYPH_HEIGHT: prdata = {26'd0, r_glyph_height};
            tcgr_pkg::REG_CHAN_POS:     prdata = {17'd0, r_chan_pos};
            tcgr_pkg::REG_CHAN_SIZE:    prdata = {20'd0, r_chan_size};
            default:                    prdata = '0;
        endcase
    end

    // The emitter can take a new row when it is idle or on its last pixel.
    assign e_free    = !r_active || (r_col == r_last_col);
    assign busy      = r_a_valid && !e_free;
    assign accept    = start && !busy;
    assign addr      = {i_item.char_code, i_item.glyph_row};
    assign render_ok = (i_item.cmd == tcgr_pkg::CMD_RENDER)
                    && ({1'b0, i_item.glyph_row} < r_glyph_height);
    assign width     = (r_glyph_width > 5'(tcgr_pkg::GLYPH_MAX_WIDTH))
                     ? 5'(tcgr_pkg::GLYPH_MAX_WIDTH) : r_glyph_width;

    // A write lands at the accept edge, so a render accepted after it already
    // reads the new row.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_item.cmd == tcgr_pkg::CMD_WRITE) begin
                r_font_mem[addr] <= i_item.font_bits;
            end else begin
                r_rd_data <= r_font_mem[addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= render_ok;
        end else if (e_free) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_attr <= i_item.attribute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (e_free) begin
            r_active <= r_a_valid && (width != 5'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_free) begin
            r_pat      <= r_rd_data;
            r_col      <= '0;
            r_last_col <= 4'(width - 5'd1);
            r_fg       <= tcgr_pkg::colour(r_a_attr[3:0], r_pixel_bytes,
                                           r_chan_pos, r_chan_size);
            r_bg       <= tcgr_pkg::colour(r_a_attr[7:4], r_pixel_bytes,
                                           r_chan_pos, r_chan_size);
        end else begin
            r_pat <= {r_pat[tcgr_pkg::FONT_W-2:0], 1'b0};
            r_col <= r_col + 4'd1;
        end
    end

    assign o_strobe                 = r_active;
    assign o_result.pixel_value     = r_pat[tcgr_pkg::FONT_W-1] ? r_fg : r_bg;
    assign o_result.pixel_column    = r_col;
    assign o_result.last_pixel      = (r_col == r_last_col);

endmodule

`default_nettype wire

### rtl/tcgr_checker.sv
// ============================================================================
// tcgr_checker
// Port-level checks of the pixel stream of the text cell glyph renderer.
// ============================================================================
`default_nettype none

module tcgr_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire tcgr_pkg::t_out_item o_result,
    input wire logic                o_strobe
);

    // A row that has not reached its last pixel goes on in the next cycle.
    a_row_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_pixel |=> o_strobe
            && (o_result.pixel_column == $past(o_result.pixel_column) + 4'd1))
        else $error("pixel row broken before its last pixel");

    // A row that follows an idle cycle starts at the leftmost column.
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> (o_result.pixel_column == 4'd0))
        else $error("pixel row does not start at column zero");

    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_pixel |=> !o_strobe
            || (o_result.pixel_column == 4'd0))
        else $error("pixel after the last one is not column zero");

    // The block only holds off new transactions while a row is going out.
    a_busy_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_strobe && !o_result.last_pixel)
        else $error("busy without a row in progress");

    a_start_held_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && busy |=> o_strobe)
        else $error("stalled transaction with an empty pixel stream");

endmodule

bind text_cell_glyph_renderer tcgr_checker u_tcgr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_result (o_result),
    .o_strobe (o_strobe)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the text cell glyph renderer.
// ============================================================================
// Font rows are loaded with write transactions and read back by render
// transactions. Each accepted render is expanded into its pixels, which are
// compared one by one with the pixel strobes of the block. The bench runs a
// directed part through the corner cases and then random phases under
// several register settings, from the smallest to the largest. It only
// renders font rows that it has already written.
// ============================================================================

module tb;

    import tcgr_pkg::*;

    // Holds a copy of the font rows and the registers, and the pixels that
    // the accepted renders still owe.
    class glyph_pixel_model;
        logic [2:0]  pix_bytes;
        logic [4:0]  width;
        logic [5:0]  height;
        logic [14:0] positions;
        logic [11:0] sizes;
        logic [15:0] font_rows [DEPTH];
        logic [23:0] vga_rgb [16];
        t_out_item   pending_px [$];
        int          errors;

        function new();
            vga_rgb = '{24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
                        24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
                        24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
                        24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff};
            pix_bytes = PIXEL_BYTES_RST;
            width     = GLYPH_WIDTH_RST;
            height    = GLYPH_HEIGHT_RST;
            positions = CHAN_POS_RST;
            sizes     = CHAN_SIZE_RST;
            errors    = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function void set_reg(input t_reg_idx idx, input logic [31:0] val);
            case (idx)
                REG_PIXEL_BYTES:  pix_bytes = val[2:0];
                REG_GLYPH_WIDTH:  width     = val[4:0];
                REG_GLYPH_HEIGHT: height    = val[5:0];
                REG_CHAN_POS:     positions = val[14:0];
                REG_CHAN_SIZE:    sizes     = val[11:0];
                default: ;
            endcase
        endfunction

        // Keeps the top bits of the channel and moves them into place; bits
        // pushed past bit 15 are lost.
        function logic [15:0] squeeze_channel(input logic [7:0] c8,
                                              input logic [3:0] sz,
                                              input logic [4:0] pos);
            logic [39:0] wide;
            int          n;
            if (sz == 4'd0) begin
                return 16'h0000;
            end
            n    = (sz > 4'd8) ? 8 : int'(sz);
            wide = 40'(c8 >> (8 - n));
            wide = wide << pos;
            return wide[15:0];
        endfunction

        function logic [23:0] pixel_colour(input logic [3:0] idx);
            logic [23:0] rgb;
            logic [15:0] pk;
            rgb = vga_rgb[idx];
            if (pix_bytes != PIXEL_BYTES_PACKED) begin
                return rgb;
            end
            pk = squeeze_channel(rgb[23:16], sizes[11:8], positions[14:10])
               | squeeze_channel(rgb[15:8],  sizes[7:4],  positions[9:5])
               | squeeze_channel(rgb[7:0],   sizes[3:0],  positions[4:0]);
            return {8'h00, pk};
        endfunction

        function void accept_item(input t_in_item it);
            logic [12:0] addr;
            logic [15:0] pattern;
            logic [23:0] fg;
            logic [23:0] bg;
            t_out_item   px;
            int          w;
            addr = {it.char_code, it.glyph_row};
            if (it.cmd == CMD_WRITE) begin
                font_rows[addr] = it.font_bits;
                return;
            end
            if ({1'b0, it.glyph_row} >= height) begin
                return;
            end
            w       = (width > 5'd16) ? 16 : int'(width);
            pattern = font_rows[addr];
            fg      = pixel_colour(it.attribute[3:0]);
            bg      = pixel_colour(it.attribute[7:4]);
            for (int col = 0; col < w; col++) begin
                px.pixel_value  = pattern[15 - col] ? fg : bg;
                px.pixel_column = col[3:0];
                px.last_pixel   = (col == w - 1);
                pending_px.push_back(px);
            end
        endfunction

        task check_pixel(input t_out_item got);
            t_out_item want;
            if (pending_px.size() == 0) begin
                report($sformatf("pixel %h col %0d with no render pending",
                                 got.pixel_value, got.pixel_column));
                return;
            end
            want = pending_px.pop_front();
            if (got.pixel_value !== want.pixel_value) begin
                report($sformatf("pixel_value %h, wanted %h (col %0d)",
                                 got.pixel_value, want.pixel_value, want.pixel_column));
            end
            if (got.pixel_column !== want.pixel_column) begin
                report($sformatf("pixel_column %0d, wanted %0d",
                                 got.pixel_column, want.pixel_column));
            end
            if (got.last_pixel !== want.last_pixel) begin
                report($sformatf("last_pixel %b, wanted %b (col %0d)",
                                 got.last_pixel, want.last_pixel, want.pixel_column));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_in_item             i_item = '0;
    logic                 o_strobe;
    t_out_item            o_result;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    glyph_pixel_model     pix_model = new();
    int                   written_addrs [$];
    bit                   is_written [DEPTH];
    logic [12:0]          last_written;
    bit                   idle_on;

    text_cell_glyph_renderer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            pix_model.check_pixel(o_result);
        end
    end

    initial begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

    // Start stays high across back-to-back transactions when no gap is drawn.
    task automatic send_item(input t_in_item it);
        int          gap;
        logic [12:0] addr;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy);
        pix_model.accept_item(it);
        if (it.cmd == CMD_WRITE) begin
            addr = {it.char_code, it.glyph_row};
            if (!is_written[addr]) begin
                is_written[addr] = 1'b1;
                written_addrs.push_back(int'(addr));
            end
            last_written = addr;
        end
    endtask

    task automatic issue(input t_cmd c, input int code, input int row,
                         input int attr, input int bits);
        t_in_item it;
        it.cmd       = c;
        it.char_code = code[7:0];
        it.glyph_row = row[4:0];
        it.attribute = attr[7:0];
        it.font_bits = bits[15:0];
        send_item(it);
    endtask

    task automatic reg_write(input t_reg_idx idx, input int val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        pix_model.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Lets every pending pixel out, plus room for renders that give none.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pix_model.pending_px.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_config(input int pb, input int w, input int h,
                              input int pos, input int sz);
        drain();
        reg_write(REG_PIXEL_BYTES, pb);
        reg_write(REG_GLYPH_WIDTH, w);
        reg_write(REG_GLYPH_HEIGHT, h);
        reg_write(REG_CHAN_POS, pos);
        reg_write(REG_CHAN_SIZE, sz);
    endtask

    task automatic random_phase(input int n_items);
        t_in_item    it;
        logic [12:0] addr;
        int          tries;
        int          hmax;
        for (int i = 0; i < n_items; i++) begin
            hmax         = (pix_model.height > 6'd32) ? 32 : int'(pix_model.height);
            it.attribute = 8'($urandom_range(0, 255));
            it.font_bits = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 99) < 35) begin
                it.cmd       = CMD_WRITE;
                it.char_code = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1 && hmax > 0) begin
                    it.glyph_row = 5'($urandom_range(0, hmax - 1));
                end else begin
                    it.glyph_row = 5'($urandom_range(0, 31));
                end
            end else begin
                it.cmd = CMD_RENDER;
                // Now and then render the row just written, to hit the
                // write followed at once by a read of the same entry.
                if ($urandom_range(0, 4) == 0) begin
                    addr = last_written;
                end else begin
                    tries = 0;
                    do begin
                        addr = 13'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
                        tries++;
                    end while (tries < 4 && {1'b0, addr[4:0]} >= pix_model.height);
                end
                it.char_code = addr[12:5];
                it.glyph_row = addr[4:0];
            end
            send_item(it);
        end
    endtask

    initial begin
        int pb;
        int w;
        int h;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        idle_on = 1'b1;

        // Reset settings: 24-bit pixels, eight columns, sixteen rows.
        issue(CMD_WRITE,  8'h00,  0, 8'h00, 16'h0000);
        issue(CMD_WRITE,  8'hff, 31, 8'hff, 16'hffff);
        issue(CMD_WRITE,  8'ha5, 15, 8'h3c, 16'ha55a);
        issue(CMD_WRITE,  8'h5a,  1, 8'hc3, 16'h8001);
        issue(CMD_WRITE,  8'hff,  0, 8'h81, 16'h00ff);
        issue(CMD_RENDER, 8'h00,  0, 8'h0f, 16'hffff);
        issue(CMD_RENDER, 8'hff,  0, 8'hf0, 16'h0000);
        issue(CMD_RENDER, 8'ha5, 15, 8'h1e, 16'h5a5a);
        issue(CMD_RENDER, 8'h5a,  1, 8'h9c, 16'h1234);
        // Row above the glyph height gives no pixels.
        issue(CMD_RENDER, 8'hff, 31, 8'h77, 16'hfedc);
        issue(CMD_WRITE,  8'h00,  0, 8'h55, 16'hffff);
        issue(CMD_RENDER, 8'h00,  0, 8'h3c, 16'h0000);

        // Packed pixels with 5:6:5 channel sizes at full width and height.
        set_config(2, 16, 32, 11013, 1381);
        issue(CMD_RENDER, 8'hff, 31, 8'h5a, 16'h0000);
        issue(CMD_RENDER, 8'ha5, 15, 8'hf0, 16'h0000);

        // Red channel empty, green wider than eight and pushed past bit 15,
        // blue wider than eight.
        set_config(2, 16, 32, 15'h0180, 12'h0f9);
        issue(CMD_RENDER, 8'h5a,  1, 8'hd4, 16'h0000);
        issue(CMD_RENDER, 8'h00,  0, 8'h2b, 16'h0000);

        // Unused pixel size and a width above the maximum.
        set_config(7, 20, 32, 0, 0);
        issue(CMD_RENDER, 8'ha5, 15, 8'he1, 16'h0000);

        // Width zero renders nothing.
        set_config(1, 0, 32, 0, 0);
        issue(CMD_RENDER, 8'h00,  0, 8'h42, 16'h0000);

        set_config(3, 1, 1, 0, 0);
        issue(CMD_RENDER, 8'h00,  0, 8'h61, 16'h0000);
        issue(CMD_RENDER, 8'hff,  0, 8'h16, 16'h0000);
        issue(CMD_RENDER, 8'ha5, 15, 8'h88, 16'h0000);

        for (int p = 0; p < 10; p++) begin
            idle_on = (p % 3 != 1);
            case (p)
                0: set_config(2, 16, 32, 11013, 1381);
                1: set_config(2, 31, 63, 32767, 4095);
                2: set_config(0, 1, 1, 0, 0);
                3: set_config(2, 8, 16, $urandom_range(0, 32767), $urandom_range(0, 4095));
                4: set_config(5, 0, 0, $urandom_range(0, 32767), $urandom_range(0, 4095));
                default: begin
                    pb = ($urandom_range(0, 1) == 1) ? 2 : $urandom_range(0, 7);
                    w  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 16);
                    h  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(1, 32);
                    set_config(pb, w, h, $urandom_range(0, 32767), $urandom_range(0, 4095));
                end
            endcase
            random_phase(24);
        end

        drain();
        if (pix_model.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
